// ===== hw/rtl/ucgp_pkg.sv =====
// Package for the Cyrillic UTF-8 glyph placer.
// Holds the glyph table, byte codes, register indexes and shared types.
// No dependencies; used by ucgp_decode and the top level.
package ucgp_pkg;

  // Lead bytes and special second bytes of two-byte Cyrillic sequences.
  localparam logic [7:0] LeadD0     = 8'hD0;
  localparam logic [7:0] LeadD1     = 8'hD1;
  localparam logic [7:0] YoUpper    = 8'h81;
  localparam logic [7:0] YoLower    = 8'h91;
  localparam logic [7:0] D0LowEnd   = 8'h95;
  localparam logic [7:0] D0MidEnd   = 8'hB6;
  localparam logic [7:0] D0LowBase  = 8'h90;
  localparam logic [7:0] D0MidBase  = 8'h8F;
  localparam logic [7:0] D0HighBase = 8'h8E;
  localparam logic [7:0] D1Base     = 8'h80;
  localparam logic [7:0] D1Offset   = 8'd50;
  localparam logic [7:0] YoUpperIdx = 8'd6;
  localparam logic [7:0] YoLowerIdx = 8'd39;

  // Longest string length used for alignment.
  localparam logic [7:0] MaxStringBytes = 8'd255;
  localparam logic [7:0] CountMax       = 8'd255;

  // Glyph table.
  localparam int unsigned TableLen = 66;
  localparam logic [7:0] CyrTable [TableLen] = '{
    8'd65,  8'd128, 8'd66,  8'd129, 8'd130, 8'd69,  8'd131, 8'd132,
    8'd133, 8'd134, 8'd135, 8'd75,  8'd136, 8'd77,  8'd72,  8'd79,
    8'd137, 8'd80,  8'd67,  8'd84,  8'd138, 8'd139, 8'd88,  8'd140,
    8'd141, 8'd142, 8'd143, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148,
    8'd149, 8'd97,  8'd150, 8'd151, 8'd152, 8'd153, 8'd101, 8'd154,
    8'd155, 8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd161, 8'd162,
    8'd111, 8'd163, 8'd112, 8'd99,  8'd164, 8'd121, 8'd165, 8'd120,
    8'd166, 8'd167, 8'd168, 8'd169, 8'd170, 8'd171, 8'd172, 8'd173,
    8'd174, 8'd175
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgOrientation = 2'd0,
    CfgWidthMax    = 2'd1,
    CfgHeightMax   = 2'd2,
    CfgFontWidth   = 2'd3
  } cfg_idx_e;

  // Alignment selector carried with the first byte of a string.
  typedef enum logic [1:0] {
    AlignModeStart  = 2'd0,
    AlignModeRight  = 2'd1,
    AlignModeCentre = 2'd2,
    AlignModeSpare  = 2'd3
  } align_mode_e;

  // Pending lead byte.
  typedef enum logic [1:0] {
    LeadNone = 2'd0,
    LeadIsD0 = 2'd1,
    LeadIsD1 = 2'd2
  } lead_e;

  // Decoder result for one byte.
  typedef struct packed {
    logic [7:0] code;
    logic       bad;
    logic       lead_start;
    lead_e      lead_kind;
  } dec_t;

  // One result item, packed as it leaves on the master side.
  typedef struct packed {
    logic [7:0]         glyph_count;
    logic               bad_sequence;
    logic               draw;
    logic [8:0]         angle_out;
    logic               rotated;
    logic [7:0]         glyph_index;
    logic signed [15:0] pixel_y;
    logic signed [16:0] pixel_x;
    logic [7:0]         glyph_code;
  } res_t;

  typedef struct packed {
    res_t data;
    logic present;
    logic last;
  } out_t;

endpackage

// ===== hw/rtl/ucgp_decode.sv =====
// Byte decoder of the Cyrillic glyph placer: maps a byte and the pending
// lead byte to a glyph code. Depends on ucgp_pkg.
module ucgp_decode (
  input  logic [7:0]     text_byte_i,
  input  ucgp_pkg::lead_e pending_i,
  output ucgp_pkg::dec_t dec_o
);

  logic [7:0] idx;
  logic       in_table;

  // Table index for the second byte of a sequence, in 8-bit wrapping math.
  always_comb begin
    idx = 8'd0;
    if (pending_i == ucgp_pkg::LeadIsD0) begin
      if (text_byte_i == ucgp_pkg::YoUpper) begin
        idx = ucgp_pkg::YoUpperIdx;
      end else if (text_byte_i <= ucgp_pkg::D0LowEnd) begin
        idx = text_byte_i - ucgp_pkg::D0LowBase;
      end else if (text_byte_i < ucgp_pkg::D0MidEnd) begin
        idx = text_byte_i - ucgp_pkg::D0MidBase;
      end else begin
        idx = text_byte_i - ucgp_pkg::D0HighBase;
      end
    end else begin
      if (text_byte_i == ucgp_pkg::YoLower) begin
        idx = ucgp_pkg::YoLowerIdx;
      end else begin
        idx = text_byte_i - ucgp_pkg::D1Base + ucgp_pkg::D1Offset;
      end
    end
  end

  assign in_table = (idx < 8'(ucgp_pkg::TableLen));

  // Classify the byte: lead byte, second byte, or pass-through.
  always_comb begin
    dec_o            = '0;
    dec_o.code       = text_byte_i;
    dec_o.lead_kind  = ucgp_pkg::LeadNone;
    if (text_byte_i[7]) begin
      if (pending_i == ucgp_pkg::LeadNone &&
          (text_byte_i == ucgp_pkg::LeadD0 || text_byte_i == ucgp_pkg::LeadD1)) begin
        dec_o.lead_start = 1'b1;
        dec_o.lead_kind  = (text_byte_i == ucgp_pkg::LeadD0) ? ucgp_pkg::LeadIsD0
                                                            : ucgp_pkg::LeadIsD1;
      end else if (pending_i != ucgp_pkg::LeadNone) begin
        if (in_table) begin
          dec_o.code = ucgp_pkg::CyrTable[idx[6:0]];
        end else begin
          dec_o.bad = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_cyrillic_glyph_placer_top.sv =====
// Throughput: one byte per cycle while the skid entry is empty; a two-entry output
// stage (register plus skid) lets a byte be taken while a finished result waits for
// the consumer. A byte's result, if it has one, is registered when the byte is accepted.
// Reset (rst_ni low, asynchronous) clears the pending lead byte, glyph counter,
// base x and output valids, and loads the registers with 0, 239, 319 and 8.
// Top level of the Cyrillic glyph placer; depends on ucgp_pkg and ucgp_decode.
module utf8_cyrillic_glyph_placer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  // Input bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // text_byte[7:0], string_byte_length[15:8], align_mode[17:16], start_x[33:18],
  // start_y[49:34], angle[58:50], measure_only[59], zero[63:60]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_of_string
  input  logic        s_axis_tuser,   // first_of_string
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // glyph_code[7:0], pixel_x[24:8], pixel_y[40:25], glyph_index[48:41], rotated[49],
  // angle_out[58:50], draw[59], bad_sequence[60], glyph_count[68:61], zero[71:69]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser    // glyph_present
);

  // Unpacked input fields.
  logic [7:0]         text_byte;
  logic [7:0]         str_len;
  logic [1:0]         align_mode;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [8:0]         angle;
  logic               measure_only;

  assign text_byte    = s_axis_tdata[7:0];
  assign str_len      = s_axis_tdata[15:8];
  assign align_mode   = s_axis_tdata[17:16];
  assign start_x      = s_axis_tdata[33:18];
  assign start_y      = s_axis_tdata[49:34];
  assign angle        = s_axis_tdata[58:50];
  assign measure_only = s_axis_tdata[59];

  // Configuration registers.
  logic       orient_q;
  logic [9:0] width_max_q;
  logic [9:0] height_max_q;
  logic [6:0] font_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q     <= 1'b0;
      width_max_q  <= 10'd239;
      height_max_q <= 10'd319;
      font_width_q <= 7'd8;
    end else if (cfg_we_i) begin
      unique case (ucgp_pkg::cfg_idx_e'(cfg_addr_i))
        ucgp_pkg::CfgOrientation: orient_q     <= cfg_wdata_i[0];
        ucgp_pkg::CfgWidthMax:    width_max_q  <= cfg_wdata_i;
        ucgp_pkg::CfgHeightMax:   height_max_q <= cfg_wdata_i;
        ucgp_pkg::CfgFontWidth:   font_width_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // String state.
  ucgp_pkg::lead_e    pend_q, pend_d, pend_eff;
  logic [7:0]         cnt_q, cnt_d, cnt_eff;
  logic signed [16:0] base_q, base_d, base_eff;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Start-of-string alignment span: limit + 1 - length * font width; centre uses half of it.
  logic [9:0]         limit;
  logic [7:0]         len_clamped;
  logic [14:0]        len_prod;
  logic signed [16:0] span;
  logic signed [16:0] span_half;

  assign limit       = orient_q ? height_max_q : width_max_q;
  assign len_clamped = (str_len > ucgp_pkg::MaxStringBytes) ? ucgp_pkg::MaxStringBytes
                                                            : str_len;
  assign len_prod    = 15'(len_clamped * font_width_q);
  assign span        = $signed({6'd0, limit} + 17'd1) - $signed({2'd0, len_prod});
  // Halve, truncating toward zero.
  assign span_half   = $signed(span + 17'(span[16])) >>> 1;

  always_comb begin
    if (s_axis_tuser) begin
      pend_eff = ucgp_pkg::LeadNone;
      cnt_eff  = 8'd0;
      case (ucgp_pkg::align_mode_e'(align_mode))
        ucgp_pkg::AlignModeRight:  base_eff = span;
        ucgp_pkg::AlignModeCentre: base_eff = span_half;
        default:                   base_eff = 17'(start_x);
      endcase
    end else begin
      pend_eff = pend_q;
      cnt_eff  = cnt_q;
      base_eff = base_q;
    end
  end

  // Byte decode.
  ucgp_pkg::dec_t dec;

  ucgp_decode u_decode (
    .text_byte_i (text_byte),
    .pending_i   (pend_eff),
    .dec_o       (dec)
  );

  // Result of the current byte.
  logic               produce;
  logic [14:0]        pos_prod;
  logic signed [16:0] glyph_x;
  logic [7:0]         cnt_next;
  ucgp_pkg::out_t     res;

  assign produce  = !dec.lead_start || s_axis_tlast;
  assign pos_prod = 15'(cnt_eff * font_width_q);
  assign glyph_x  = base_eff + $signed({2'd0, pos_prod});
  assign cnt_next = (cnt_eff < ucgp_pkg::CountMax) ? cnt_eff + 8'd1 : ucgp_pkg::CountMax;

  always_comb begin
    res      = '0;
    res.last = s_axis_tlast;
    if (dec.lead_start) begin
      res.data.glyph_count = cnt_eff;
    end else begin
      res.present           = 1'b1;
      res.data.glyph_code   = dec.code;
      res.data.pixel_x      = (angle == 9'd0) ? glyph_x : base_eff;
      res.data.pixel_y      = start_y;
      res.data.glyph_index  = cnt_eff;
      res.data.rotated      = (angle != 9'd0);
      res.data.angle_out    = angle;
      res.data.draw         = !measure_only;
      res.data.bad_sequence = dec.bad;
      res.data.glyph_count  = cnt_next;
    end
  end

  // Next string state.
  always_comb begin
    pend_d = dec.lead_start ? dec.lead_kind : ucgp_pkg::LeadNone;
    cnt_d  = dec.lead_start ? cnt_eff : cnt_next;
    base_d = base_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= ucgp_pkg::LeadNone;
      cnt_q  <= 8'd0;
      base_q <= '0;
    end else if (in_acc) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      base_q <= base_d;
    end
  end

  // Output register with a skid entry.
  logic           main_vld_q, skid_vld_q;
  ucgp_pkg::out_t main_q, skid_q;
  logic           take, push;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign push          = in_acc && produce;
  assign s_axis_tready = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (main_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        main_vld_q <= 1'b1;
      end
    end else if (take) begin
      main_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (main_vld_q && !take) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

  assign m_axis_tvalid = main_vld_q;
  assign m_axis_tdata  = {3'd0, main_q.data};
  assign m_axis_tlast  = main_q.last;
  assign m_axis_tuser  = main_q.present;

endmodule

// ===== hw/rtl/ucgp_checker.sv =====
// Port-level checker for the Cyrillic glyph placer top level, with its bind.
// Depends only on the top level's ports.
module ucgp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An empty result only ends a string and carries nothing but the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[60:0] == 61'd0)
    else $error("empty result carries data");

  // The rotated flag follows the angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[49] == (m_axis_tdata[58:50] != 9'd0))
    else $error("rotated flag disagrees with angle");

  // A glyph's count is its index plus one, saturating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[48:41] != 8'd255
      |-> m_axis_tdata[68:61] == m_axis_tdata[48:41] + 8'd1)
    else $error("glyph count does not follow index");

endmodule

bind utf8_cyrillic_glyph_placer_top ucgp_checker u_ucgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
